[rtl/core/speck128_cbc_decrypt_core_macros.svh]
// Assertion helpers for the block decrypt core.
`ifndef SPECK128_CBC_DECRYPT_CORE_MACROS_SVH
`define SPECK128_CBC_DECRYPT_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define S128D_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define S128D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/s128d_pkg.sv]
package s128d_pkg;

    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int ROT_A     = 8;
    localparam int ROT_B     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

    localparam logic REQ_LOAD_IV = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  req_type;
        word_t word_first;
        word_t word_second;
        logic  is_last;
    } in_word_t;

    typedef struct packed {
        word_t plain_first;
        word_t plain_second;
        logic  last_out;
    } out_word_t;

    function automatic word_t rotl64(input word_t v, input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic word_t rotr64(input word_t v, input int unsigned s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

endpackage

[rtl/core/speck128_cbc_decrypt_core.sv]
// Speck-style 128/128 CBC decrypt core, 64-bit words, ROUND_COUNT rounds.
// Key words are to be written by the user on the cfg port (index 0 low word,
// index 1 high word) only while the core is idle; the core does not enforce
// this. Any key write forces a fresh key expansion.
// Input words (s_valid/s_ready): req_type 0 loads the IV and gives no output;
// req_type 1 decrypts one block and yields one output word on m_valid/m_ready.
// s_ready is high only in the idle state; one block is worked at a time.
// A block runs one inverse round per cycle through a single round unit, keys
// read from the round-key RAM. The first block after reset or a key write
// first runs the key schedule, which writes one round key per cycle.
// The output register holds a finished word while the receiver stalls; the
// core still accepts one more word meanwhile and waits before overwriting it.
// Reset clears keys, chaining value and handshake state; the chaining value
// is zero until the first IV load or the first finished block.
`include "speck128_cbc_decrypt_core_macros.svh"

module speck128_cbc_decrypt_core #(
    parameter int ROUND_COUNT = 45
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [s128d_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [s128d_pkg::WORD_W-1:0]          cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  s128d_pkg::in_word_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output s128d_pkg::out_word_t                  m_data
);
    import s128d_pkg::*;

    localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_RND = IDX_W'(ROUND_COUNT - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] rnd_reg;
    word_t            key_low_reg;
    word_t            key_high_reg;
    logic             keys_expanded_reg;
    word_t            chain_first_reg;
    word_t            chain_second_reg;
    word_t            x_reg;
    word_t            y_reg;
    word_t            cx_reg;
    word_t            cy_reg;
    logic             last_reg;
    out_word_t        out_reg;
    logic             m_valid_reg;

    logic             accept;
    logic             is_decrypt;
    logic             out_free;
    logic             ks_start;
    logic             ks_done;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    word_t            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    word_t            round_key;
    word_t            x_step;
    word_t            y_step;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign is_decrypt = (s_data.req_type == REQ_DECRYPT);
    assign out_free   = !m_valid_reg || m_ready;
    assign ks_start   = accept && is_decrypt && !keys_expanded_reg;
    assign ram_raddr  = (state_reg == ST_ROUND && rnd_reg != '0) ? rnd_reg - 1'b1 : LAST_RND;

    s128d_ksched #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_ksched (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ks_start),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .done     (ks_done)
    );

    s128d_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ROUND_COUNT)
    ) u_rk_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(round_key)
    );

    s128d_round u_round (
        .x_in     (x_reg),
        .y_in     (y_reg),
        .round_key(round_key),
        .x_out    (x_step),
        .y_out    (y_step)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_decrypt) begin
                    state_next = keys_expanded_reg ? ST_ROUND : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (ks_done) begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (rnd_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            key_low_reg       <= '0;
            key_high_reg      <= '0;
            keys_expanded_reg <= 1'b0;
            chain_first_reg   <= '0;
            chain_second_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_KEY_LOW: begin
                        key_low_reg       <= cfg_wdata;
                        keys_expanded_reg <= 1'b0;
                    end
                    CFG_KEY_HIGH: begin
                        key_high_reg      <= cfg_wdata;
                        keys_expanded_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (ks_done) begin
                keys_expanded_reg <= 1'b1;
            end
            if (accept && !is_decrypt) begin
                chain_first_reg  <= s_data.word_first;
                chain_second_reg <= s_data.word_second;
            end else if (state_reg == ST_OUT && out_free) begin
                chain_first_reg  <= cx_reg;
                chain_second_reg <= cy_reg;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= s_data.word_first;
            y_reg    <= s_data.word_second;
            cx_reg   <= s_data.word_first;
            cy_reg   <= s_data.word_second;
            last_reg <= s_data.is_last;
        end else if (state_reg == ST_ROUND) begin
            x_reg <= x_step;
            y_reg <= y_step;
        end
        if ((accept && keys_expanded_reg) || state_reg == ST_PRIME) begin
            rnd_reg <= LAST_RND;
        end else if (state_reg == ST_ROUND) begin
            rnd_reg <= rnd_reg - 1'b1;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_reg.plain_first  <= x_reg ^ chain_first_reg;
            out_reg.plain_second <= y_reg ^ chain_second_reg;
            out_reg.last_out     <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `S128D_ASSERT_NOW(a_keys_ready, aclk, aresetn, state_reg == ST_ROUND, keys_expanded_reg, "round key read before expansion")
    `S128D_ASSERT_NOW(a_ram_write_in_expand, aclk, aresetn, ram_we, state_reg == ST_EXPAND, "round-key write outside expansion")
    `S128D_ASSERT_NEXT(a_last_round_to_out, aclk, aresetn, state_reg == ST_ROUND && rnd_reg == '0, state_reg == ST_OUT, "final round did not move to output")
    `S128D_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, state_reg == ST_OUT && m_valid_reg && !m_ready, state_reg == ST_OUT && m_valid_reg, "pending word overwritten under stall")

endmodule

[rtl/core/s128d_ram.sv]
module s128d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 45
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/s128d_ksched.sv]
module s128d_ksched #(
    parameter int ROUND_COUNT = 45
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             start,
    input  s128d_pkg::word_t                                 key_low,
    input  s128d_pkg::word_t                                 key_high,
    output logic                                             ram_we,
    output logic [((ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1)-1:0] ram_waddr,
    output s128d_pkg::word_t                                 ram_wdata,
    output logic                                             done
);
    import s128d_pkg::*;

    localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_RND = IDX_W'(ROUND_COUNT - 1);

    logic             active_reg;
    logic [IDX_W-1:0] cnt_reg;
    word_t            k_reg;
    word_t            b_reg;
    word_t            b_next;
    word_t            k_next;

    assign b_next = (rotr64(b_reg, ROT_A) + k_reg) ^ WORD_W'(cnt_reg);
    assign k_next = rotl64(k_reg, ROT_B) ^ b_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end else if (start) begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end else if (active_reg) begin
            if (cnt_reg == LAST_RND) begin
                active_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            k_reg <= key_low;
            b_reg <= key_high;
        end else if (active_reg) begin
            k_reg <= k_next;
            b_reg <= b_next;
        end
    end

    assign ram_we    = active_reg;
    assign ram_waddr = cnt_reg;
    assign ram_wdata = k_reg;
    assign done      = active_reg && (cnt_reg == LAST_RND);

endmodule

[rtl/core/s128d_round.sv]
module s128d_round (
    input  s128d_pkg::word_t x_in,
    input  s128d_pkg::word_t y_in,
    input  s128d_pkg::word_t round_key,
    output s128d_pkg::word_t x_out,
    output s128d_pkg::word_t y_out
);
    import s128d_pkg::*;

    word_t y_mix;

    assign y_mix = rotr64(y_in ^ x_in, ROT_B);
    assign y_out = y_mix;
    assign x_out = rotl64((x_in ^ round_key) - y_mix, ROT_A);

endmodule

[verif/speck128_cbc_decrypt_core_tb.sv]
module speck128_cbc_decrypt_core_tb;

    import s128d_pkg::*;

    localparam int          ROUNDS         = 45;
    localparam int unsigned SETTLE_CYCLES  = 2 * ROUNDS + 10;
    localparam int unsigned RX_HOLD_CYCLES = 600;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_GAP        = 18;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_word_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_word_t            m_data;

    speck128_cbc_decrypt_core #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    word_t       kw_low;
    word_t       kw_high;
    word_t       sched_keys [ROUNDS];
    bit          sched_valid;
    word_t       chain_x;
    word_t       chain_y;
    out_word_t   plain_expected_q [$];

    int unsigned err_count   = 0;
    int unsigned shown_count = 0;
    int unsigned idle_cycles = 0;
    bit          tx_no_idle  = 1'b0;
    bit          rx_no_idle  = 1'b0;
    bit          hold_req    = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic word_t spin_left(input word_t v, input int unsigned s);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << s;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic word_t spin_right(input word_t v, input int unsigned s);
        logic [2*WORD_W-1:0] d;
        d = {v, v} >> s;
        return d[WORD_W-1:0];
    endfunction

    function automatic word_t rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic in_word_t make_word(input logic rt, input word_t a, input word_t b,
                                           input logic l);
        in_word_t w;
        w.req_type    = rt;
        w.word_first  = a;
        w.word_second = b;
        w.is_last     = l;
        return w;
    endfunction

    task automatic expand_schedule();
        word_t b;
        b = kw_high;
        sched_keys[0] = kw_low;
        for (int r = 0; r < ROUNDS - 1; r++) begin
            b = (spin_right(b, ROT_A) + sched_keys[r]) ^ word_t'(r);
            sched_keys[r+1] = spin_left(sched_keys[r], ROT_B) ^ b;
        end
        sched_valid = 1'b1;
    endtask

    task automatic predict_block(input in_word_t w);
        word_t     x;
        word_t     y;
        out_word_t res;
        x = w.word_first;
        y = w.word_second;
        if (w.req_type == REQ_LOAD_IV) begin
            chain_x = x;
            chain_y = y;
        end else begin
            if (!sched_valid) expand_schedule();
            for (int r = ROUNDS; r > 0; r--) begin
                y = spin_right(y ^ x, ROT_B);
                x = spin_left((x ^ sched_keys[r-1]) - y, ROT_A);
            end
            res.plain_first  = x ^ chain_x;
            res.plain_second = y ^ chain_y;
            res.last_out     = w.is_last;
            plain_expected_q.push_back(res);
            chain_x = w.word_first;
            chain_y = w.word_second;
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_KEY_LOW) begin
            kw_low      = val;
            sched_valid = 1'b0;
        end else if (idx == CFG_KEY_HIGH) begin
            kw_high     = val;
            sched_valid = 1'b0;
        end
    endtask

    task automatic send_word(input in_word_t w);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_block(w);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (plain_expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_word(make_word(REQ_DECRYPT, '0, '0, 1'b0));
        send_word(make_word(REQ_DECRYPT, '1, '1, 1'b1));
        send_word(make_word(REQ_LOAD_IV, '1, '1, 1'b1));
        send_word(make_word(REQ_DECRYPT, '0, '1, 1'b0));
        send_word(make_word(REQ_DECRYPT, '1, '0, 1'b1));
        send_word(make_word(REQ_LOAD_IV, '0, '0, 1'b0));
        send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), 1'b1));
        settle();
        write_cfg(CFG_KEY_LOW, '1);
        write_cfg(CFG_KEY_HIGH, '1);
        send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), 1'b0));
        send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), 1'b1));
        settle();
        write_cfg(CFG_KEY_LOW, rand_word());
        send_word(make_word(REQ_LOAD_IV, rand_word(), rand_word(), 1'b0));
        send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), 1'b1));
        settle();
        write_cfg(CFG_KEY_HIGH, rand_word());
        send_word(make_word(REQ_LOAD_IV, rand_word(), rand_word(), 1'b1));
        send_word(make_word(REQ_LOAD_IV, rand_word(), rand_word(), 1'b0));
        send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), 1'b0));
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        for (int i = 0; i < 4; i++) begin
            send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), i == 3));
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        settle();
    endtask

    task automatic test_random_messages();
        word_t       lo;
        word_t       hi;
        int unsigned sent;
        int unsigned len;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin lo = '0; hi = '1; end
                1: begin lo = '1; hi = '0; end
                2: begin lo = '1; hi = '1; end
                7: begin lo = '0; hi = '0; end
                default: begin lo = rand_word(); hi = rand_word(); end
            endcase
            if (p != 5) write_cfg(CFG_KEY_LOW, lo);
            write_cfg(CFG_KEY_HIGH, hi);
            tx_no_idle = (p == 3) || (p == 6);
            rx_no_idle = (p == 4) || (p == 6);
            sent = 0;
            while (sent < 130) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_word(make_word(REQ_LOAD_IV, rand_word(), rand_word(),
                                        1'($urandom_range(0, 1))));
                    len = $urandom_range(1, 8);
                    for (int k = 0; k < len; k++) begin
                        send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(),
                                            k == len - 1));
                    end
                    sent += len + 1;
                end else begin
                    send_word(make_word(1'($urandom_range(0, 1)), rand_word(), rand_word(),
                                        1'($urandom_range(0, 1))));
                    sent++;
                end
            end
            tx_no_idle = 1'b0;
            rx_no_idle = 1'b0;
            settle();
        end
    endtask

    task automatic test_output_backpressure();
        hold_req   = 1'b1;
        tx_no_idle = 1'b1;
        send_word(make_word(REQ_LOAD_IV, rand_word(), rand_word(), 1'b0));
        for (int i = 0; i < 24; i++) begin
            send_word(make_word(REQ_DECRYPT, rand_word(), rand_word(), i == 23));
        end
        tx_no_idle = 1'b0;
        settle();
    endtask

    initial begin : receiver
        int unsigned gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && !hold_req);
        end
    end

    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (plain_expected_q.size() == 0) begin
                err_count++;
                if (shown_count < 10) begin
                    shown_count++;
                    $display("unexpected result: first %h second %h last %b",
                             m_data.plain_first, m_data.plain_second, m_data.last_out);
                end
            end else begin
                exp_w = plain_expected_q.pop_front();
                if (m_data.plain_first !== exp_w.plain_first ||
                    m_data.plain_second !== exp_w.plain_second ||
                    m_data.last_out !== exp_w.last_out) begin
                    err_count++;
                    if (shown_count < 10) begin
                        shown_count++;
                        $display("mismatch: expected %h %h %b, got %h %h %b",
                                 exp_w.plain_first, exp_w.plain_second, exp_w.last_out,
                                 m_data.plain_first, m_data.plain_second, m_data.last_out);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("speck128_cbc_decrypt_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        kw_low      = '0;
        kw_high     = '0;
        sched_valid = 1'b0;
        chain_x     = '0;
        chain_y     = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_messages();
        test_output_backpressure();
        settle();
        err_count += plain_expected_q.size();
        if (err_count == 0) begin
            $display("speck128_cbc_decrypt_core_tb: done, clean");
        end else begin
            $display("speck128_cbc_decrypt_core_tb: done, errors");
        end
        $finish;
    end

endmodule
